### hdl/scit_pkg.sv
// Package: widths, payload types and part codes for the segment/circle intersection test.
`timescale 1ns / 1ps

package scit_pkg;

  // Coordinate width; every other width follows from it
  localparam int unsigned COORD_WIDTH = 16;

  // Coordinate difference, its products and sums of two products
  localparam int unsigned DIFF_W = COORD_WIDTH + 1;
  localparam int unsigned PROD_W = 2 * DIFF_W;
  localparam int unsigned SUM_W  = PROD_W + 1;

  // Squared radius, magnitudes fed to the wide multipliers, final products
  localparam int unsigned R2_W   = 2 * COORD_WIDTH;
  localparam int unsigned MAG_W  = 2 * COORD_WIDTH + 1;
  localparam int unsigned HALF_W = COORD_WIDTH + 1;
  localparam int unsigned PP_W   = 2 * HALF_W;
  localparam int unsigned ACC_W  = 4 * HALF_W;
  localparam int unsigned WIDE_W = 2 * MAG_W;

  // Register stages ahead of the output register
  localparam int unsigned STAGES = 6;

  typedef enum logic [1:0] {
    PART_START    = 2'd0,
    PART_END      = 2'd1,
    PART_INTERIOR = 2'd2
  } part_e;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] start_x;
    logic signed [COORD_WIDTH-1:0] start_y;
    logic signed [COORD_WIDTH-1:0] end_x;
    logic signed [COORD_WIDTH-1:0] end_y;
    logic signed [COORD_WIDTH-1:0] centre_x;
    logic signed [COORD_WIDTH-1:0] centre_y;
    logic        [COORD_WIDTH-1:0] radius;
  } in_t;

  typedef struct packed {
    logic  hit;
    part_e closest_part;
  } out_t;

  // Squared lengths, projection and cross product after the sum stage
  typedef struct packed {
    logic signed [SUM_W-1:0] l2;
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] cr;
    logic signed [SUM_W-1:0] p2;
    logic signed [SUM_W-1:0] q2;
    logic        [R2_W-1:0]  r2;
  } metrics_t;

  // Classification that rides along with the wide multiplies
  typedef struct packed {
    part_e part;
    logic  ep_hit;
  } class_t;

endpackage

### hdl/scit_front.sv
// Front end: coordinate differences, narrow products and their sums (three stages).
`timescale 1ns / 1ps

module scit_front (
  input  logic                clk_i,
  input  logic                en_i,
  input  scit_pkg::in_t       in_data_i,
  output scit_pkg::metrics_t  metrics_o
);

  localparam int unsigned W = scit_pkg::COORD_WIDTH;

  // Stage 1: differences
  logic signed [scit_pkg::DIFF_W-1:0] dx_d, dy_d, px_d, py_d, qx_d, qy_d;
  logic signed [scit_pkg::DIFF_W-1:0] dx_q, dy_q, px_q, py_q, qx_q, qy_q;
  logic        [W-1:0]                r_q;

  // Stage 2: products
  logic signed [scit_pkg::PROD_W-1:0] dxdx_q, dydy_q, dxpx_q, dypy_q, dxpy_q, dypx_q;
  logic signed [scit_pkg::PROD_W-1:0] pxpx_q, pypy_q, qxqx_q, qyqy_q;
  logic        [scit_pkg::R2_W-1:0]   r2_q;

  // Stage 3: sums
  scit_pkg::metrics_t metrics_d, metrics_q;

  // end - start, centre - start, centre - end, each one bit wider
  always_comb begin
    dx_d = {in_data_i.end_x[W-1], in_data_i.end_x}
         - {in_data_i.start_x[W-1], in_data_i.start_x};
    dy_d = {in_data_i.end_y[W-1], in_data_i.end_y}
         - {in_data_i.start_y[W-1], in_data_i.start_y};
    px_d = {in_data_i.centre_x[W-1], in_data_i.centre_x}
         - {in_data_i.start_x[W-1], in_data_i.start_x};
    py_d = {in_data_i.centre_y[W-1], in_data_i.centre_y}
         - {in_data_i.start_y[W-1], in_data_i.start_y};
    qx_d = {in_data_i.centre_x[W-1], in_data_i.centre_x}
         - {in_data_i.end_x[W-1], in_data_i.end_x};
    qy_d = {in_data_i.centre_y[W-1], in_data_i.centre_y}
         - {in_data_i.end_y[W-1], in_data_i.end_y};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q <= dx_d;
      dy_q <= dy_d;
      px_q <= px_d;
      py_q <= py_d;
      qx_q <= qx_d;
      qy_q <= qy_d;
      r_q  <= in_data_i.radius;
    end
  end

  // One narrow multiplier per product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dxdx_q <= scit_pkg::PROD_W'(dx_q * dx_q);
      dydy_q <= scit_pkg::PROD_W'(dy_q * dy_q);
      dxpx_q <= scit_pkg::PROD_W'(dx_q * px_q);
      dypy_q <= scit_pkg::PROD_W'(dy_q * py_q);
      dxpy_q <= scit_pkg::PROD_W'(dx_q * py_q);
      dypx_q <= scit_pkg::PROD_W'(dy_q * px_q);
      pxpx_q <= scit_pkg::PROD_W'(px_q * px_q);
      pypy_q <= scit_pkg::PROD_W'(py_q * py_q);
      qxqx_q <= scit_pkg::PROD_W'(qx_q * qx_q);
      qyqy_q <= scit_pkg::PROD_W'(qy_q * qy_q);
      r2_q   <= scit_pkg::R2_W'(r_q * r_q);
    end
  end

  // Squared lengths, dot product and cross product
  always_comb begin
    metrics_d.l2 = scit_pkg::SUM_W'(dxdx_q) + scit_pkg::SUM_W'(dydy_q);
    metrics_d.t  = scit_pkg::SUM_W'(dxpx_q) + scit_pkg::SUM_W'(dypy_q);
    metrics_d.cr = scit_pkg::SUM_W'(dxpy_q) - scit_pkg::SUM_W'(dypx_q);
    metrics_d.p2 = scit_pkg::SUM_W'(pxpx_q) + scit_pkg::SUM_W'(pypy_q);
    metrics_d.q2 = scit_pkg::SUM_W'(qxqx_q) + scit_pkg::SUM_W'(qyqy_q);
    metrics_d.r2 = r2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      metrics_q <= metrics_d;
    end
  end

  assign metrics_o = metrics_q;

endmodule

### hdl/scit_classify.sv
// Classifier: picks the closest part, does the endpoint test and forms the wide operands.
`timescale 1ns / 1ps

module scit_classify (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  scit_pkg::metrics_t         metrics_i,
  output logic [scit_pkg::MAG_W-1:0] cr_mag_o,
  output logic [scit_pkg::MAG_W-1:0] l2_mag_o,
  output logic [scit_pkg::MAG_W-1:0] r2_o,
  output scit_pkg::class_t           class_o
);

  logic signed [scit_pkg::SUM_W-1:0] r2_s;
  logic signed [scit_pkg::SUM_W-1:0] cr_neg;
  logic signed [scit_pkg::SUM_W-1:0] cr_abs;
  logic                              p_lt, q_lt;
  scit_pkg::class_t                  class_d;
  scit_pkg::class_t                  class_q, class_dly1_q, class_dly2_q;
  logic [scit_pkg::MAG_W-1:0]        cr_mag_q, l2_mag_q, r2_q;

  // Part selection; a zero-length segment is tested as its start point
  always_comb begin
    r2_s   = $signed({{(scit_pkg::SUM_W - scit_pkg::R2_W){1'b0}}, metrics_i.r2});
    p_lt   = metrics_i.p2 < r2_s;
    q_lt   = metrics_i.q2 < r2_s;
    cr_neg = -metrics_i.cr;
    cr_abs = metrics_i.cr[scit_pkg::SUM_W-1] ? cr_neg : metrics_i.cr;

    if ((metrics_i.l2 == '0) || metrics_i.t[scit_pkg::SUM_W-1]) begin
      class_d.part   = scit_pkg::PART_START;
      class_d.ep_hit = p_lt;
    end else if (metrics_i.l2 < metrics_i.t) begin
      class_d.part   = scit_pkg::PART_END;
      class_d.ep_hit = q_lt;
    end else begin
      class_d.part   = scit_pkg::PART_INTERIOR;
      class_d.ep_hit = 1'b0;
    end
  end

  // Stage 4 register, then two delay stages matching the wide multipliers
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cr_mag_q     <= cr_abs[scit_pkg::MAG_W-1:0];
      l2_mag_q     <= metrics_i.l2[scit_pkg::MAG_W-1:0];
      r2_q         <= scit_pkg::MAG_W'(metrics_i.r2);
      class_q      <= class_d;
      class_dly1_q <= class_q;
      class_dly2_q <= class_dly1_q;
    end
  end

  assign cr_mag_o = cr_mag_q;
  assign l2_mag_o = l2_mag_q;
  assign r2_o     = r2_q;
  assign class_o  = class_dly2_q;

endmodule

### hdl/scit_wide_mul.sv
// Wide unsigned multiplier: four half-width partial products, then one summing stage.
`timescale 1ns / 1ps

module scit_wide_mul (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [scit_pkg::MAG_W-1:0]  a_i,
  input  logic [scit_pkg::MAG_W-1:0]  b_i,
  output logic [scit_pkg::WIDE_W-1:0] p_o
);

  localparam int unsigned H = scit_pkg::HALF_W;

  logic [2*H-1:0]                 a_ext, b_ext;
  logic [scit_pkg::PP_W-1:0]      ll_q, lh_q, hl_q, hh_q;
  logic [scit_pkg::ACC_W-1:0]     acc;
  logic [scit_pkg::WIDE_W-1:0]    p_q;

  assign a_ext = {{(2*H - scit_pkg::MAG_W){1'b0}}, a_i};
  assign b_ext = {{(2*H - scit_pkg::MAG_W){1'b0}}, b_i};

  // Partial products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= scit_pkg::PP_W'(a_ext[H-1:0]   * b_ext[H-1:0]);
      lh_q <= scit_pkg::PP_W'(a_ext[H-1:0]   * b_ext[2*H-1:H]);
      hl_q <= scit_pkg::PP_W'(a_ext[2*H-1:H] * b_ext[H-1:0]);
      hh_q <= scit_pkg::PP_W'(a_ext[2*H-1:H] * b_ext[2*H-1:H]);
    end
  end

  // Shift and add; the true product always fits the result width
  always_comb begin
    acc = scit_pkg::ACC_W'(ll_q)
        + (scit_pkg::ACC_W'(lh_q) << H)
        + (scit_pkg::ACC_W'(hl_q) << H)
        + (scit_pkg::ACC_W'(hh_q) << (2*H));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= acc[scit_pkg::WIDE_W-1:0];
    end
  end

  assign p_o = p_q;

endmodule

### hdl/scit_out_buf.sv
// Output stage: final interior compare, output register and one skid entry.
`timescale 1ns / 1ps

module scit_out_buf (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        pipe_valid_i,
  input  logic [scit_pkg::WIDE_W-1:0] sq_cross_i,
  input  logic [scit_pkg::WIDE_W-1:0] bound_i,
  input  scit_pkg::class_t            class_i,
  output logic                        pipe_en_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output scit_pkg::out_t              out_data_o
);

  scit_pkg::out_t res;
  scit_pkg::out_t out_data_d, out_data_q, skid_data_d, skid_data_q;
  logic           out_valid_d, out_valid_q, skid_valid_d, skid_valid_q;
  logic           take;

  // Interior: (d x p)^2 < r^2 * |d|^2; endpoints were decided upstream
  always_comb begin
    res.closest_part = class_i.part;
    if (class_i.part == scit_pkg::PART_INTERIOR) begin
      res.hit = sq_cross_i < bound_i;
    end else begin
      res.hit = class_i.ep_hit;
    end
  end

  // Output register with skid; the pipeline holds while the skid is full
  always_comb begin
    take         = out_valid_q & ~out_stall_i;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (skid_valid_q) begin
      if (take) begin
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (pipe_valid_i) begin
      if (!out_valid_q || take) begin
        out_valid_d = 1'b1;
        out_data_d  = res;
      end else begin
        skid_valid_d = 1'b1;
        skid_data_d  = res;
      end
    end else if (take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign pipe_en_o   = ~skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

### hdl/segment_circle_intersect_test_top.sv
// Top level of the segment/circle intersection test pipeline.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------
//   in      | input     | in_valid_i / in_stall_o    | in_data_i  (scit_pkg::in_t)
//   out     | output    | out_valid_o / out_stall_i  | out_data_o (scit_pkg::out_t)
//
// One transaction per cycle while in_stall_o is low; the accepting edge loads the first
// of six pipeline register stages (differences, products, sums, classify, partial
// products, summing), and the output register loads after the last of them.
// The two wide interior-test products are each split into four half-width partial
// products across two stages.
// Reset clears only valid bits; payload registers are not reset.
// A stalled result waits in the output register while the pipeline keeps moving;
// a second one goes to the skid entry, and only then does in_stall_o rise.
`timescale 1ns / 1ps

module segment_circle_intersect_test_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  scit_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output scit_pkg::out_t  out_data_o
);

  logic                          pipe_en;
  logic [scit_pkg::STAGES-1:0]   valid_q;
  scit_pkg::metrics_t            metrics;
  logic [scit_pkg::MAG_W-1:0]    cr_mag, l2_mag, r2;
  scit_pkg::class_t              cls;
  logic [scit_pkg::WIDE_W-1:0]   sq_cross, bound;

  // Valid bits travel with the data and freeze with it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (pipe_en) begin
      valid_q <= {valid_q[scit_pkg::STAGES-2:0], in_valid_i};
    end
  end

  assign in_stall_o = ~pipe_en;

  scit_front u_front (
    .clk_i     (clk_i),
    .en_i      (pipe_en),
    .in_data_i (in_data_i),
    .metrics_o (metrics)
  );

  scit_classify u_classify (
    .clk_i     (clk_i),
    .en_i      (pipe_en),
    .metrics_i (metrics),
    .cr_mag_o  (cr_mag),
    .l2_mag_o  (l2_mag),
    .r2_o      (r2),
    .class_o   (cls)
  );

  // (d x p)^2
  scit_wide_mul u_mul_cross (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .a_i   (cr_mag),
    .b_i   (cr_mag),
    .p_o   (sq_cross)
  );

  // r^2 * |d|^2
  scit_wide_mul u_mul_bound (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .a_i   (r2),
    .b_i   (l2_mag),
    .p_o   (bound)
  );

  scit_out_buf u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .pipe_valid_i (valid_q[scit_pkg::STAGES-1]),
    .sq_cross_i   (sq_cross),
    .bound_i      (bound),
    .class_i      (cls),
    .pipe_en_o    (pipe_en),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

### hdl/scit_checker.sv
// Port-level checker for the segment/circle intersection test, bound to the top level.
`timescale 1ns / 1ps

module scit_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input scit_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input scit_pkg::out_t out_data_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result holds its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  // Input is held off only while a result waits at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with an empty output");

  // Input stall only starts after the output was stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("input stall without a downstream stall");

  // A stalled input transaction stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input changed while stalled");

endmodule

bind segment_circle_intersect_test_top scit_checker u_scit_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
